// ===== hdl/prefix_code_symbol_decoder_top_assert.svh =====
// Assertion macros for the prefix code symbol decoder.
// Included by the top level; no other dependencies.
`ifndef PREFIX_CODE_SYMBOL_DECODER_TOP_ASSERT_SVH
`define PREFIX_CODE_SYMBOL_DECODER_TOP_ASSERT_SVH
`ifndef SYNTH
// check prop on every edge outside reset
`define PCSD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check prop on every edge, reset included
`define PCSD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCSD_ASSERT(label, clk, rst, prop, msg)
`define PCSD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/pcsd_pkg.sv =====
// Shared types, code tables and helper functions of the prefix code decoder.
// No dependencies.
package pcsd_pkg;

  localparam int MID_DEPTH = 2;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  localparam int          NUM_CW    = 32;
  localparam logic [3:0]  BUF_BITS  = 4'd12;
  localparam logic [2:0]  SYM_SLOTS = 3'd4;

  // codeword patterns (right aligned), lengths and decoded symbols
  localparam logic [7:0] CW_PATTERN [NUM_CW] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h01, 8'h04, 8'h05, 8'h06,
    8'h07, 8'h11, 8'h10, 8'h09, 8'h05, 8'h06, 8'h07, 8'h08,
    8'h90, 8'h91, 8'h92, 8'h93, 8'h25, 8'h98, 8'h99, 8'h9A,
    8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'h05, 8'h06, 8'h07
  };
  localparam logic [3:0] CW_LENGTH [NUM_CW] = '{
    4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd6, 4'd8, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd3, 4'd3
  };
  localparam logic [7:0] CW_SYMBOL [NUM_CW] = '{
    8'h27, 8'h3F, 8'h57, 8'h2C, 8'h44, 8'h4C, 8'h4F, 8'h53,
    8'h54, 8'h2E, 8'h48, 8'h46, 8'h43, 8'h4B, 8'h49, 8'h52,
    8'h5A, 8'h2D, 8'h58, 8'h59, 8'h41, 8'h4A, 8'h4D, 8'h42,
    8'h47, 8'h55, 8'h56, 8'h4E, 8'h51, 8'h20, 8'h45, 8'h50
  };

  typedef struct packed {
    logic       ok;
    logic [4:0] bits;
  } sym_map_t;

  // item handed from front to back
  typedef struct packed {
    logic [4:0] bits;
    logic       sym_ok;
    logic       has_char;
    logic       line_end;
  } mid_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_of_line;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] len;
    logic [7:0] sym;
  } cw_hit_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DECODE,
    BK_TERM
  } back_state_t;

  function automatic sym_map_t char_to_bits(input logic [7:0] c);
    sym_map_t m;
    m.ok   = 1'b1;
    m.bits = 5'd0;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      m.bits = 5'(c - 8'h41);
    end else begin
      unique case (c)
        8'h20:   m.bits = 5'd26;  // space
        8'h2E:   m.bits = 5'd27;  // period
        8'h2C:   m.bits = 5'd28;  // comma
        8'h2D:   m.bits = 5'd29;  // dash
        8'h27:   m.bits = 5'd30;  // apostrophe
        8'h3F:   m.bits = 5'd31;  // question mark
        default: m.ok   = 1'b0;
      endcase
    end
    return m;
  endfunction

  // win holds the oldest 8 pending bits, left aligned; cnt is the fill
  function automatic cw_hit_t cw_lookup(input logic [7:0] win, input logic [3:0] cnt);
    cw_hit_t r;
    r.hit = 1'b0;
    r.len = 4'd0;
    r.sym = 8'd0;
    for (int i = 0; i < NUM_CW; i++) begin
      if (!r.hit && CW_LENGTH[i] <= cnt &&
          (win >> (4'd8 - CW_LENGTH[i])) == CW_PATTERN[i]) begin
        r.hit = 1'b1;
        r.len = CW_LENGTH[i];
        r.sym = CW_SYMBOL[i];
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/pcsd_front.sv =====
// Front end: maps input characters to 5-bit values and queues items.
// Depends on pcsd_pkg.
module pcsd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            in_char,
  input  logic                  has_char,
  input  logic                  line_end,
  output logic                  full,
  output logic                  mid_valid,
  output pcsd_pkg::mid_item_t   mid_item,
  input  logic                  mid_pop
);
  import pcsd_pkg::*;

  mid_item_t         mem [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr;
  logic [MID_AW-1:0] rd_ptr;
  logic [MID_AW:0]   count;
  sym_map_t          map;
  logic              do_push;
  logic              do_pop;

  assign map       = char_to_bits(in_char);
  assign full      = (count == (MID_AW+1)'(MID_DEPTH));
  assign mid_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = mid_pop && mid_valid;
  assign mid_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{bits: map.bits, sym_ok: map.ok, has_char: has_char,
                       line_end: line_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/pcsd_back.sv =====
// Back end: bit buffer and decode sequencer, one symbol per cycle while the result queue has room.
// Depends on pcsd_pkg.
module pcsd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                mid_valid,
  input  pcsd_pkg::mid_item_t mid_item,
  output logic                mid_pop,
  output logic                res_push,
  output pcsd_pkg::res_t      res_item,
  input  logic                res_full
);
  import pcsd_pkg::*;

  back_state_t state, state_next;
  logic [11:0] bit_buffer, bit_buffer_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [2:0]  slots, slots_next;
  logic        eol_pend, eol_pend_next;

  logic [11:0] aligned;
  cw_hit_t     cw;
  logic        can_emit;
  logic [3:0]  rem_count;
  logic [4:0]  fill_sum;

  // left-align pending bits so the oldest sits at bit 11
  assign aligned   = bit_buffer << (BUF_BITS - bit_count);
  assign cw        = cw_lookup(aligned[11:4], bit_count);
  assign can_emit  = cw.hit && (slots != SYM_SLOTS);
  assign rem_count = bit_count - cw.len;
  assign fill_sum  = {1'b0, bit_count} + 5'd5;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (mid_valid) begin
          priority if (mid_item.has_char) state_next = BK_DECODE;
          else if (mid_item.line_end)     state_next = BK_TERM;
          else                            state_next = BK_IDLE;
        end
      end
      BK_DECODE: begin
        if (!can_emit) state_next = eol_pend ? BK_TERM : BK_IDLE;
      end
      BK_TERM: begin
        if (!res_full) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    mid_pop  = 1'b0;
    res_push = 1'b0;
    res_item = '{out_char: 8'd0, char_valid: 1'b0, last_of_line: 1'b1};
    unique case (state)
      BK_IDLE: mid_pop = mid_valid;
      BK_DECODE: begin
        res_push = can_emit && !res_full;
        res_item = '{out_char: cw.sym, char_valid: 1'b1, last_of_line: 1'b0};
      end
      BK_TERM: res_push = !res_full;
      default: ;
    endcase
  end

  always_comb begin
    bit_buffer_next = bit_buffer;
    bit_count_next  = bit_count;
    slots_next      = slots;
    eol_pend_next   = eol_pend;
    unique case (state)
      BK_IDLE: begin
        if (mid_valid) begin
          slots_next    = 3'd0;
          eol_pend_next = mid_item.line_end;
          if (mid_item.has_char && mid_item.sym_ok && fill_sum <= {1'b0, BUF_BITS}) begin
            bit_buffer_next = {bit_buffer[6:0], mid_item.bits};
            bit_count_next  = fill_sum[3:0];
          end
        end
      end
      BK_DECODE: begin
        if (can_emit && !res_full) begin
          bit_count_next  = rem_count;
          bit_buffer_next = bit_buffer & ~(12'hFFF << rem_count);
          slots_next      = slots + 3'd1;
        end
      end
      BK_TERM: begin
        if (!res_full) begin
          bit_buffer_next = 12'd0;
          bit_count_next  = 4'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      bit_buffer <= 12'd0;
      bit_count  <= 4'd0;
      slots      <= 3'd0;
      eol_pend   <= 1'b0;
    end else begin
      state      <= state_next;
      bit_buffer <= bit_buffer_next;
      bit_count  <= bit_count_next;
      slots      <= slots_next;
      eol_pend   <= eol_pend_next;
    end
  end

endmodule

// ===== hdl/pcsd_res_fifo.sv =====
// Result queue between the decode sequencer and the output ports.
// Depends on pcsd_pkg.
module pcsd_res_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pcsd_pkg::res_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pcsd_pkg::res_t head_item
);
  import pcsd_pkg::*;

  res_t              mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;
  logic [OUT_AW:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (OUT_AW+1)'(OUT_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/prefix_code_symbol_decoder_top.sv =====
// Top level of the prefix code symbol decoder: front end, decode back end,
// result queue. Depends on pcsd_pkg and the assertion macro header.
//
//   channel  | handshake    | payload
//   ---------+--------------+-----------------------------------
//   input    | push / full  | in_char, has_char, line_end
//   result   | empty / pop  | out_char, char_valid, last_of_line
//
// The back end sequencer takes one item at a time from the 2-entry front
// queue; for an item with a character, it emits one decoded symbol at a time
// until no further codeword is found, then the terminator on a line end.
// A bare line end yields only the terminator, an empty item nothing.
// Full and empty come straight from queue counters; each side stalls alone.
// Synchronous reset empties both queues and clears the bit buffer.
module prefix_code_symbol_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       has_char,
  input  logic       line_end,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       last_of_line
);
  import pcsd_pkg::*;

  logic      mid_valid;
  mid_item_t mid_item;
  logic      mid_pop;
  logic      res_push;
  res_t      res_item;
  logic      res_full;
  res_t      head_item;

  pcsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_char   (in_char),
    .has_char  (has_char),
    .line_end  (line_end),
    .full      (full),
    .mid_valid (mid_valid),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop)
  );

  pcsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  pcsd_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_item (res_item),
    .full      (res_full),
    .pop       (pop),
    .empty     (empty),
    .head_item (head_item)
  );

  assign out_char     = head_item.out_char;
  assign char_valid   = head_item.char_valid;
  assign last_of_line = head_item.last_of_line;

`include "prefix_code_symbol_decoder_top_assert.svh"

  `PCSD_ASSERT(a_no_push_full, clk, rst, res_push |-> !res_full, "result pushed while full")
  `PCSD_ASSERT(a_no_pop_empty, clk, rst, mid_pop |-> mid_valid, "front queue popped empty")
  `PCSD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "results left after reset")
  `PCSD_ASSERT(a_term_shape, clk, rst, (res_push && res_item.last_of_line) |-> (!res_item.char_valid && res_item.out_char == 8'd0), "bad terminator item")

endmodule

// ===== tb/sv/tb_prefix_code_symbol_decoder_top.sv =====
// Self-checking testbench for prefix_code_symbol_decoder_top: a directed table,
// then random encoded lines, checked against an in-bench prefix decoder or, for typed rows, hand-written results.
// Depends only on the RTL of the decoder top level.
`timescale 1ns / 100ps

module tb_prefix_code_symbol_decoder_top;

  localparam int N_RANDOM   = 120;
  localparam int MAX_SYMS   = 4;
  localparam int DRAIN_CYC  = 20;
  localparam int CYCLE_CAP  = 300000;
  localparam int N_DIR      = 25;

  // 32-entry prefix code: right-aligned pattern, length, decoded symbol
  localparam int CW_BITS [32] = '{
    'h00, 'h01, 'h02, 'h03, 'h01, 'h04, 'h05, 'h06,
    'h07, 'h11, 'h10, 'h09, 'h05, 'h06, 'h07, 'h08,
    'h90, 'h91, 'h92, 'h93, 'h25, 'h98, 'h99, 'h9A,
    'h9B, 'h9C, 'h9D, 'h9E, 'h9F, 'h05, 'h06, 'h07
  };
  localparam int CW_LEN [32] = '{
    6, 6, 6, 6, 4, 5, 5, 5,
    5, 6, 6, 5, 4, 4, 4, 4,
    8, 8, 8, 8, 6, 8, 8, 8,
    8, 8, 8, 8, 8, 3, 3, 3
  };
  localparam logic [7:0] CW_SYM [32] = '{
    "'", "?", "W", ",", "D", "L", "O", "S",
    "T", ".", "H", "F", "C", "K", "I", "R",
    "Z", "-", "X", "Y", "A", "J", "M", "B",
    "G", "U", "V", "N", "Q", " ", "E", "P"
  };
  // alphabet codes 26..31
  localparam logic [7:0] PUNCT [6] = '{" ", ".", ",", "-", "'", "?"};

  typedef enum logic {
    CHK_MODEL,
    CHK_TYPED
  } chk_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eol;
    chk_mode_t  mode;
    logic       sym_n;   // typed rows: one symbol expected
    logic [7:0] sym;
    logic       term;    // typed rows: terminator expected
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{8'h00, 1'b0, 1'b1, CHK_TYPED, 1'b0, 8'h00, 1'b1},  // bare line end after reset
    '{8'hFF, 1'b0, 1'b0, CHK_TYPED, 1'b0, 8'h00, 1'b0},  // empty item
    '{8'h00, 1'b1, 1'b1, CHK_TYPED, 1'b0, 8'h00, 1'b1},  // non-alphabet byte, line end
    '{"?",   1'b1, 1'b1, CHK_TYPED, 1'b1, "P",   1'b1},  // 11111 -> P, tail dropped
    '{"A",   1'b1, 1'b0, CHK_TYPED, 1'b0, 8'h00, 1'b0},  // 00000: no codeword yet
    '{"A",   1'b1, 1'b1, CHK_TYPED, 1'b1, "'",   1'b1},  // 000000 -> apostrophe
    '{8'hFF, 1'b1, 1'b0, CHK_TYPED, 1'b0, 8'h00, 1'b0},
    '{"Z",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"E",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{" ",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{".",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{",",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"-",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"'",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"Q",   1'b1, 1'b1, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{8'h61, 1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},  // lower case is skipped
    '{8'h40, 1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},  // just below 'A'
    '{8'h5B, 1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},  // just above 'Z'
    '{8'h80, 1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"M",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"U",   1'b0, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},  // char ignored, has_char low
    '{"B",   1'b0, 1'b1, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"D",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"O",   1'b1, 1'b0, CHK_MODEL, 1'b0, 8'h00, 1'b0},
    '{"K",   1'b1, 1'b1, CHK_MODEL, 1'b0, 8'h00, 1'b0}
  };

  typedef struct {
    logic [7:0] ch;
    logic       vld;
    logic       last;
  } sym_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_char = 8'h00;
  logic       has_char = 1'b0;
  logic       line_end = 1'b0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last_of_line;

  sym_res_t    pending_syms[$];
  logic [11:0] pend_bits = 12'd0;
  logic [3:0]  pend_cnt = 4'd0;
  int          mismatches = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          rx_hold = 0;
  int          rx_gap;
  sym_res_t    rx_want;

  prefix_code_symbol_decoder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_char      (in_char),
    .has_char     (has_char),
    .line_end     (line_end),
    .pop          (pop),
    .empty        (empty),
    .out_char     (out_char),
    .char_valid   (char_valid),
    .last_of_line (last_of_line)
  );

  always #5 clk = ~clk;

  // 5-bit code of an alphabet character, -1 for any other byte
  function automatic int char_code(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'(8'h41);
    for (int i = 0; i < 6; i++) begin
      if (c == PUNCT[i]) return 26 + i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] alpha_char(input int k);
    if (k < 26) return 8'(8'h41 + k);
    return PUNCT[k - 26];
  endfunction

  // idle length for one item; runs of zero-wait items come and go
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // decode one accepted item into pending_syms
  task automatic decode_item(input logic [7:0] ch, input logic has, input logic eol);
    int       code;
    int       found;
    int       front;
    sym_res_t r;
    if (has) begin
      code = char_code(ch);
      if (code >= 0) begin
        pend_bits = {pend_bits[6:0], 5'(code)};
        pend_cnt  = pend_cnt + 4'd5;
      end
      for (int n = 0; n < MAX_SYMS; n++) begin
        found = -1;
        for (int k = 0; k < 32; k++) begin
          if (found < 0 && CW_LEN[k] <= int'(pend_cnt)) begin
            front = (int'(pend_bits) >> (int'(pend_cnt) - CW_LEN[k])) &
                    ((1 << CW_LEN[k]) - 1);
            if (front == CW_BITS[k]) found = k;
          end
        end
        if (found < 0) break;
        pend_cnt  = pend_cnt - 4'(CW_LEN[found]);
        pend_bits = pend_bits & ((12'd1 << pend_cnt) - 12'd1);
        r.ch   = CW_SYM[found];
        r.vld  = 1'b1;
        r.last = 1'b0;
        pending_syms.push_back(r);
      end
    end
    if (eol) begin
      pend_bits = 12'd0;
      pend_cnt  = 4'd0;
      r.ch   = 8'h00;
      r.vld  = 1'b0;
      r.last = 1'b1;
      pending_syms.push_back(r);
    end
  endtask

  // returns right after the accepting edge with push still high
  task automatic send_item(input logic [7:0] ch, input logic has, input logic eol);
    int gap;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    in_char  <= ch;
    has_char <= has;
    line_end <= eol;
    do @(posedge clk); while (full);
  endtask

  // result side: random pop stalls, compare with the oldest pending item
  always @(posedge clk) begin
    if (rst) begin
      pop     <= 1'b0;
      rx_hold <= 0;
    end else if (pop && !empty) begin
      if (pending_syms.size() == 0) begin
        report_mismatch("result with nothing pending", out_char, 0);
      end else begin
        rx_want = pending_syms.pop_front();
        if (out_char !== rx_want.ch) report_mismatch("out_char", out_char, rx_want.ch);
        if (char_valid !== rx_want.vld)
          report_mismatch("char_valid", char_valid, rx_want.vld);
        if (last_of_line !== rx_want.last)
          report_mismatch("last_of_line", last_of_line, rx_want.last);
      end
      rx_gap = draw_wait(rx_burst);
      if (rx_gap == 0) begin
        pop <= 1'b1;
      end else begin
        pop     <= 1'b0;
        rx_hold <= rx_gap;
      end
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) pop <= 1'b1;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("prefix_code_symbol_decoder_top: mismatch");
    $finish;
  end

  initial begin
    int         n0;
    int         live_items;
    int         line_len;
    int         sel;
    bit         paused;
    logic [7:0] ch;
    logic       has;
    logic       eol;
    sym_res_t   r;

    live_items = 0;
    paused     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      send_item(DIR_ROWS[i].ch, DIR_ROWS[i].has, DIR_ROWS[i].eol);
      n0 = pending_syms.size();
      decode_item(DIR_ROWS[i].ch, DIR_ROWS[i].has, DIR_ROWS[i].eol);
      if (DIR_ROWS[i].mode == CHK_TYPED) begin
        // keep the decoder state, but expect the hand-written results
        while (pending_syms.size() > n0) void'(pending_syms.pop_back());
        if (DIR_ROWS[i].sym_n) begin
          r.ch   = DIR_ROWS[i].sym;
          r.vld  = 1'b1;
          r.last = 1'b0;
          pending_syms.push_back(r);
        end
        if (DIR_ROWS[i].term) begin
          r.ch   = 8'h00;
          r.vld  = 1'b0;
          r.last = 1'b1;
          pending_syms.push_back(r);
        end
      end
    end

    // random lines: mostly alphabet text, some skipped bytes and empty items
    while (live_items < N_RANDOM) begin
      line_len = $urandom_range(0, 12);
      for (int j = 0; j <= line_len; j++) begin
        eol = (j == line_len);
        sel = $urandom_range(0, 19);
        if (sel < 16) begin
          ch  = alpha_char($urandom_range(0, 31));
          has = 1'b1;
        end else begin
          ch  = 8'($urandom_range(0, 255));
          has = (sel < 18);
        end
        if ((has && char_code(ch) >= 0) || eol) live_items++;
        send_item(ch, has, eol);
        decode_item(ch, has, eol);
        if (!paused && live_items >= N_RANDOM / 2) begin
          // hold the input side until the decoder has fully drained
          paused = 1'b1;
          push <= 1'b0;
          @(posedge clk);
          while (pending_syms.size() != 0) @(posedge clk);
        end
      end
    end
    push <= 1'b0;

    while (pending_syms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && pending_syms.size() == 0) begin
      $display("prefix_code_symbol_decoder_top: match");
    end else begin
      $display("prefix_code_symbol_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
